@@ design/pti_pkg.sv @@
// ============================================================================
// pti_pkg
// Shared constants and helpers for the pre-integrated transfer function table.
// ============================================================================
package pti_pkg;

    // Fixed-point format of entries and results
    localparam int FRAC_BITS         = 16;
    localparam int COMP_W            = 16;
    localparam int IDX_W             = 8;
    localparam int NUM_COMP          = 4;
    localparam int DEF_TABLE_ENTRIES = 256;

    // Exponential series works in Q2.30
    localparam int EXP_BITS  = 30;
    localparam int EXP_SHIFT = EXP_BITS - FRAC_BITS;
    localparam int EXP_TERMS = 16;
    localparam int RCP_SHIFT = 31;
    localparam int ACC_W     = EXP_BITS + 3;

    localparam logic [COMP_W-1:0] FMASK = COMP_W'((1 << FRAC_BITS) - 1);
    localparam logic [ACC_W-1:0]  EXP_ONE = ACC_W'(1) << EXP_BITS;

    // Item kinds carried in tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Channel numbering
    localparam logic [4:0] CH_BLUE  = 5'd2;
    localparam logic [4:0] CH_ALPHA = 5'd3;

    // floor(2^31 / k) for the series divisors k = 1..16
    function automatic logic [31:0] recip_of(input logic [4:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                5'd1:    r = 32'd2147483648;
                5'd2:    r = 32'd1073741824;
                5'd3:    r = 32'd715827882;
                5'd4:    r = 32'd536870912;
                5'd5:    r = 32'd429496729;
                5'd6:    r = 32'd357913941;
                5'd7:    r = 32'd306783378;
                5'd8:    r = 32'd268435456;
                5'd9:    r = 32'd238609294;
                5'd10:   r = 32'd214748364;
                5'd11:   r = 32'd195225786;
                5'd12:   r = 32'd178956970;
                5'd13:   r = 32'd165191049;
                5'd14:   r = 32'd153391689;
                5'd15:   r = 32'd143165576;
                5'd16:   r = 32'd134217728;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ design/pti_ram.sv @@
// ============================================================================
// pti_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/preintegrated_transfer_function_top.sv @@
// Load item: a restart or first entry gets zero prefix sums; others multiply and add per
// color before the write. An item on a full table without restart is dropped. Query item:
// out of range gives zeros with index_error; equal indices scale color by alpha; unequal
// indices divide prefix differences. Sets: one shared 32x32 multiplier (16-term exp series)
// and a one-bit-per-cycle divider for the four means. One item at a time.
// Reset clears the sequencer, the entry count and the output valid; tables are not cleared.
// ============================================================================
// preintegrated_transfer_function_top
// Pre-integrated transfer function table: loads RGBA entries with running
// prefix sums and answers front/back segment queries.
// ============================================================================
module preintegrated_transfer_function_top
    import pti_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tf_red, tf_green, tf_blue, tf_alpha, front_index, back_index
    input  logic [79:0] s_axis_tdata,
    // func, restart_table
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, out_opacity
    output logic [63:0] m_axis_tdata,
    // index_error
    output logic [0:0]  m_axis_tuser
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int PW     = FRAC_BITS + ADDR_W;
    localparam int NB     = PW + 1;
    localparam int BC_W   = $clog2(NB);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_LOAD  = 20'h00002,
        S_LMUL  = 20'h00004,
        S_LADD  = 20'h00008,
        S_LWR   = 20'h00010,
        S_QCHK  = 20'h00020,
        S_ERD   = 20'h00040,
        S_EMUL  = 20'h00080,
        S_EADD  = 20'h00100,
        S_QRD1  = 20'h00200,
        S_QRD2  = 20'h00400,
        S_DSET  = 20'h00800,
        S_DIV   = 20'h01000,
        S_XINIT = 20'h02000,
        S_XM1   = 20'h04000,
        S_XM2   = 20'h08000,
        S_XM3   = 20'h10000,
        S_XFIX  = 20'h20000,
        S_XFIN  = 20'h40000,
        S_DONE  = 20'h80000
    } state_t;

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers
    logic               rst_tbl_reg, rst_tbl_next;
    logic [COMP_W-1:0]  cin_reg [NUM_COMP];
    logic [COMP_W-1:0]  cin_next [NUM_COMP];
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [IDX_W-1:0]   bidx_reg, bidx_next;
    logic [COMP_W-1:0]  last_c_reg [NUM_COMP];
    logic [COMP_W-1:0]  last_c_next [NUM_COMP];
    logic [PW-1:0]      last_p_reg [NUM_COMP];
    logic [PW-1:0]      last_p_next [NUM_COMP];
    logic [PW-1:0]      pnew_reg [NUM_COMP];
    logic [PW-1:0]      pnew_next [NUM_COMP];
    logic [PW-1:0]      phi_reg [NUM_COMP];
    logic [PW-1:0]      phi_next [NUM_COMP];
    logic [COMP_W-1:0]  res_reg [NUM_COMP];
    logic [COMP_W-1:0]  res_next [NUM_COMP];
    logic               err_reg, err_next;
    logic [COMP_W-1:0]  a_reg, a_next;
    logic [4:0]         k_reg, k_next;
    logic [ADDR_W-1:0]  widx_reg, widx_next;
    logic [ADDR_W-1:0]  lo_reg, lo_next;
    logic [ADDR_W-1:0]  d_reg, d_next;
    logic [63:0]        prod_reg, prod_next;
    logic [NB-1:0]      n_reg, n_next;
    logic [ADDR_W-1:0]  rem_reg, rem_next;
    logic [BC_W-1:0]    bit_reg, bit_next;
    logic [EXP_BITS-1:0] x_reg, x_next;
    logic [EXP_BITS:0]  term_reg, term_next;
    logic [EXP_BITS-1:0] v_reg, v_next;
    logic [EXP_BITS-1:0] q0_reg, q0_next;
    logic [ACC_W-1:0]   pos_reg, pos_next;
    logic [ACC_W-1:0]   neg_reg, neg_next;
    logic [63:0]        mdata_reg, mdata_next;
    logic               muser_reg, muser_next;

    // Combinational helpers
    logic [31:0]        mul_a, mul_b;
    logic [1:0]         ch;
    logic [17:0]        adj_sum;
    logic [16:0]        csum;
    logic [63:0]        rnd_sum;
    logic [CMP_W-1:0]   fe, be, cnt_ext, lo_ext, hi_ext;
    logic [ADDR_W:0]    div_sh, div_sub;
    logic               qbit;
    logic [NB-1:0]      qnext;
    logic [COMP_W-1:0]  qsat;
    logic [EXP_BITS:0]  fix_r, fix_q;
    logic [ACC_W-1:0]   e_diff, e_clamp, op_val, op_rnd;
    logic [ACC_W-1:0]   op_sh;

    // Memories
    logic               raw_we, pfx_we;
    logic [ADDR_W-1:0]  raw_raddr, pfx_raddr;
    logic [63:0]        raw_rdata;
    logic [NUM_COMP*PW-1:0] pfx_rdata;
    logic [NUM_COMP*PW-1:0] pfx_wdata;

    pti_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_ENTRIES)
    ) u_raw_ram (
        .clk   (clk),
        .we    (raw_we),
        .waddr (widx_reg),
        .wdata ({cin_reg[3], cin_reg[2], cin_reg[1], cin_reg[0]}),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    pti_ram #(
        .WIDTH (NUM_COMP * PW),
        .DEPTH (TABLE_ENTRIES)
    ) u_pfx_ram (
        .clk   (clk),
        .we    (pfx_we),
        .waddr (widx_reg),
        .wdata (pfx_wdata),
        .raddr (pfx_raddr),
        .rdata (pfx_rdata)
    );

    assign pfx_wdata = {pnew_reg[3], pnew_reg[2], pnew_reg[1], pnew_reg[0]};

    // Handshake outputs
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = muser_reg;

    // Datapath helpers
    assign ch      = k_reg[1:0];
    assign adj_sum = {2'b0, last_c_reg[3]} + {2'b0, cin_reg[3]} + 18'd1;
    assign csum    = {1'b0, last_c_reg[ch]} + {1'b0, cin_reg[ch]};
    assign fe      = CMP_W'(fidx_reg);
    assign be      = CMP_W'(bidx_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign lo_ext  = (fe < be) ? fe : be;
    assign hi_ext  = (fe < be) ? be : fe;
    assign div_sh  = {rem_reg, n_reg[NB-1]};
    assign div_sub = div_sh - {1'b0, d_reg};
    assign qbit    = (div_sh >= {1'b0, d_reg});
    assign qnext   = {n_reg[NB-2:0], qbit};
    assign qsat    = (qnext > NB'(FMASK)) ? FMASK : qnext[COMP_W-1:0];
    assign fix_r   = (EXP_BITS+1)'(v_reg) - prod_reg[EXP_BITS:0];
    assign fix_q   = (fix_r >= (EXP_BITS+1)'(k_reg)) ? ((EXP_BITS+1)'(q0_reg) + 1'b1)
                                                      : (EXP_BITS+1)'(q0_reg);
    assign e_diff  = (pos_reg > neg_reg) ? (pos_reg - neg_reg) : '0;
    assign e_clamp = (e_diff > EXP_ONE) ? EXP_ONE : e_diff;
    assign op_val  = EXP_ONE - e_clamp;
    assign op_rnd  = op_val + (ACC_W'(1) << (EXP_SHIFT - 1));
    assign op_sh   = op_rnd >> EXP_SHIFT;

    // Read addresses: first read issued while checking the query
    always_comb
    begin
        if (state_reg == S_QCHK)
        begin
            raw_raddr = lo_ext[ADDR_W-1:0];
            pfx_raddr = hi_ext[ADDR_W-1:0];
        end
        else
        begin
            raw_raddr = lo_reg;
            pfx_raddr = lo_reg;
        end
    end

    // Sequencer and shared multiplier operands
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        rst_tbl_next = rst_tbl_reg;
        fidx_next    = fidx_reg;
        bidx_next    = bidx_reg;
        err_next     = err_reg;
        a_next       = a_reg;
        k_next       = k_reg;
        widx_next    = widx_reg;
        lo_next      = lo_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        rem_next     = rem_reg;
        bit_next     = bit_reg;
        x_next       = x_reg;
        term_next    = term_reg;
        v_next       = v_reg;
        q0_next      = q0_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        for (int j = 0; j < NUM_COMP; j++)
        begin
            cin_next[j]    = cin_reg[j];
            last_c_next[j] = last_c_reg[j];
            last_p_next[j] = last_p_reg[j];
            pnew_next[j]   = pnew_reg[j];
            phi_next[j]    = phi_reg[j];
            res_next[j]    = res_reg[j];
        end
        mul_a   = '0;
        mul_b   = '0;
        raw_we  = 1'b0;
        pfx_we  = 1'b0;
        rnd_sum = '0;

        // Drop the output item once taken
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rst_tbl_next = s_axis_tuser[1];
                    for (int j = 0; j < NUM_COMP; j++)
                    begin
                        cin_next[j] = s_axis_tdata[j*COMP_W +: COMP_W] & FMASK;
                    end
                    fidx_next  = s_axis_tdata[71:64];
                    bidx_next  = s_axis_tdata[79:72];
                    state_next = (s_axis_tuser[0] == FUNC_QUERY) ? S_QCHK : S_LOAD;
                end
            end

            S_LOAD:
            begin
                if (!rst_tbl_reg && (count_reg == CNT_W'(TABLE_ENTRIES)))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    widx_next = rst_tbl_reg ? '0 : count_reg[ADDR_W-1:0];
                    if (rst_tbl_reg || (count_reg == '0))
                    begin
                        for (int j = 0; j < NUM_COMP; j++)
                        begin
                            pnew_next[j] = '0;
                        end
                        state_next = S_LWR;
                    end
                    else
                    begin
                        a_next       = adj_sum[16:1];
                        pnew_next[3] = last_p_reg[3] + PW'(adj_sum[16:1]);
                        k_next       = '0;
                        state_next   = S_LMUL;
                    end
                end
            end

            S_LMUL:
            begin
                mul_a      = 32'(csum);
                mul_b      = 32'(a_reg);
                state_next = S_LADD;
            end

            S_LADD:
            begin
                rnd_sum       = prod_reg + (64'(1) << FRAC_BITS);
                pnew_next[ch] = last_p_reg[ch] + PW'(rnd_sum >> (FRAC_BITS + 1));
                if (k_reg == CH_BLUE)
                begin
                    state_next = S_LWR;
                end
                else
                begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_LMUL;
                end
            end

            S_LWR:
            begin
                raw_we = 1'b1;
                pfx_we = 1'b1;
                for (int j = 0; j < NUM_COMP; j++)
                begin
                    last_c_next[j] = cin_reg[j];
                    last_p_next[j] = pnew_reg[j];
                end
                count_next = CNT_W'(widx_reg) + CNT_W'(1);
                state_next = S_IDLE;
            end

            S_QCHK:
            begin
                if ((fe >= cnt_ext) || (be >= cnt_ext))
                begin
                    for (int j = 0; j < NUM_COMP; j++)
                    begin
                        res_next[j] = '0;
                    end
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    err_next   = 1'b0;
                    lo_next    = lo_ext[ADDR_W-1:0];
                    d_next     = hi_ext[ADDR_W-1:0] - lo_ext[ADDR_W-1:0];
                    state_next = (fe == be) ? S_ERD : S_QRD1;
                end
            end

            // Equal indices: color times alpha
            S_ERD:
            begin
                for (int j = 0; j < NUM_COMP; j++)
                begin
                    cin_next[j] = raw_rdata[j*COMP_W +: COMP_W];
                end
                a_next     = raw_rdata[63:48];
                k_next     = '0;
                state_next = S_EMUL;
            end

            S_EMUL:
            begin
                mul_a      = 32'(cin_reg[ch]);
                mul_b      = 32'(a_reg);
                state_next = S_EADD;
            end

            S_EADD:
            begin
                rnd_sum = (prod_reg + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
                res_next[ch] = (rnd_sum > 64'(FMASK)) ? FMASK : rnd_sum[COMP_W-1:0];
                if (k_reg == CH_BLUE)
                begin
                    state_next = S_XINIT;
                end
                else
                begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_EMUL;
                end
            end

            // Unequal indices: prefix differences
            S_QRD1:
            begin
                for (int j = 0; j < NUM_COMP; j++)
                begin
                    phi_next[j] = pfx_rdata[j*PW +: PW];
                end
                state_next = S_QRD2;
            end

            S_QRD2:
            begin
                for (int j = 0; j < NUM_COMP; j++)
                begin
                    phi_next[j] = phi_reg[j] - pfx_rdata[j*PW +: PW];
                end
                k_next     = '0;
                state_next = S_DSET;
            end

            S_DSET:
            begin
                n_next     = NB'(phi_reg[ch]) + NB'(d_reg >> 1);
                rem_next   = '0;
                bit_next   = BC_W'(NB - 1);
                state_next = S_DIV;
            end

            // Restoring divide, one quotient bit a cycle
            S_DIV:
            begin
                n_next   = qnext;
                rem_next = qbit ? div_sub[ADDR_W-1:0] : div_sh[ADDR_W-1:0];
                if (bit_reg == '0)
                begin
                    if (k_reg == CH_ALPHA)
                    begin
                        a_next     = qsat;
                        state_next = S_XINIT;
                    end
                    else
                    begin
                        res_next[ch] = qsat;
                        k_next       = k_reg + 5'd1;
                        state_next   = S_DSET;
                    end
                end
                else
                begin
                    bit_next = bit_reg - BC_W'(1);
                end
            end

            // Series for exp(-x), one term per pass
            S_XINIT:
            begin
                x_next     = {a_reg, {EXP_SHIFT{1'b0}}};
                term_next  = EXP_ONE[EXP_BITS:0];
                pos_next   = EXP_ONE;
                neg_next   = '0;
                k_next     = 5'd1;
                state_next = S_XM1;
            end

            S_XM1:
            begin
                mul_a      = 32'(term_reg);
                mul_b      = 32'(x_reg);
                state_next = S_XM2;
            end

            S_XM2:
            begin
                v_next     = prod_reg[2*EXP_BITS-1:EXP_BITS];
                mul_a      = 32'(prod_reg[2*EXP_BITS-1:EXP_BITS]);
                mul_b      = recip_of(k_reg);
                state_next = S_XM3;
            end

            S_XM3:
            begin
                q0_next    = prod_reg[RCP_SHIFT+EXP_BITS-1:RCP_SHIFT];
                mul_a      = 32'(prod_reg[RCP_SHIFT+EXP_BITS-1:RCP_SHIFT]);
                mul_b      = 32'(k_reg);
                state_next = S_XFIX;
            end

            S_XFIX:
            begin
                term_next = fix_q;
                if (k_reg[0])
                begin
                    neg_next = neg_reg + ACC_W'(fix_q);
                end
                else
                begin
                    pos_next = pos_reg + ACC_W'(fix_q);
                end
                if (k_reg == 5'(EXP_TERMS))
                begin
                    state_next = S_XFIN;
                end
                else
                begin
                    k_next     = k_reg + 5'd1;
                    state_next = S_XM1;
                end
            end

            S_XFIN:
            begin
                res_next[3] = (op_sh > ACC_W'(FMASK)) ? FMASK : op_sh[COMP_W-1:0];
                state_next  = S_DONE;
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    mdata_next   = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    muser_next   = err_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rst_tbl_reg <= rst_tbl_next;
        fidx_reg    <= fidx_next;
        bidx_reg    <= bidx_next;
        err_reg     <= err_next;
        a_reg       <= a_next;
        k_reg       <= k_next;
        widx_reg    <= widx_next;
        lo_reg      <= lo_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        n_reg       <= n_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        x_reg       <= x_next;
        term_reg    <= term_next;
        v_reg       <= v_next;
        q0_reg      <= q0_next;
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        mdata_reg   <= mdata_next;
        muser_reg   <= muser_next;
        for (int j = 0; j < NUM_COMP; j++)
        begin
            cin_reg[j]    <= cin_next[j];
            last_c_reg[j] <= last_c_next[j];
            last_p_reg[j] <= last_p_next[j];
            pnew_reg[j]   <= pnew_next[j];
            phi_reg[j]    <= phi_next[j];
            res_reg[j]    <= res_next[j];
        end
    end

endmodule
